// ===== rtl/core/pdc_pkg.sv =====
package pdc_pkg;

  // Porter-Duff operator codes
  typedef enum logic [3:0] {
    OP_SRC      = 4'd0,
    OP_DST      = 4'd1,
    OP_OVER     = 4'd2,
    OP_DST_OVER = 4'd3,
    OP_IN       = 4'd4,
    OP_DST_IN   = 4'd5,
    OP_OUT      = 4'd6,
    OP_DST_OUT  = 4'd7,
    OP_ATOP     = 4'd8,
    OP_DST_ATOP = 4'd9,
    OP_CLEAR    = 4'd10,
    OP_XOR      = 4'd11
  } pdc_op_e;

  // How the result color is formed
  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_SRC  = 2'd1,
    MODE_DST  = 2'd2,
    MODE_MIX  = 2'd3
  } pdc_mode_e;

  localparam int unsigned NumChan       = 3;
  localparam int unsigned QuoBits       = 8;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = QuoBits / StepsPerStage;
  localparam logic [7:0]  FullScale     = 8'd255;

  // One color channel inside the divider
  typedef struct packed {
    logic       fix;   // result already known, no division
    logic [7:0] rem;   // partial remainder
    logic [7:0] num;   // dividend bits still to shift in
    logic [7:0] quo;   // quotient, or the fixed result
  } pdc_chan_t;

  typedef struct packed {
    pdc_chan_t [NumChan-1:0] ch;
    logic [7:0]              alpha;  // divisor and result alpha
  } pdc_div_t;

  // round(x*y/255) as (x*y+127)/255
  function automatic logic [7:0] mul255(input logic [7:0] x, input logic [7:0] y);
    logic [16:0] n;
    logic [16:0] q;
    n = 17'(x) * 17'(y) + 17'd127;
    q = n + 17'(n[16:8]) + 17'd1;
    return q[15:8];
  endfunction

  // One restoring division step on a channel
  function automatic pdc_chan_t div_step(input pdc_chan_t c, input logic [7:0] a);
    pdc_chan_t  r;
    logic [8:0] r2;
    r  = c;
    r2 = {c.rem, c.num[7]};
    if (!c.fix) begin
      r.num = {c.num[6:0], 1'b0};
      if (r2 >= {1'b0, a}) begin
        r.rem = 8'(r2 - {1'b0, a});
        r.quo = {c.quo[6:0], 1'b1};
      end else begin
        r.rem = r2[7:0];
        r.quo = {c.quo[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pdc_unpremul.sv =====
module pdc_unpremul
  import pdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  pdc_div_t data_i,
  output logic     valid_o,
  input  logic     stall_i,
  output pdc_div_t data_o
);

  logic     v_q [DivStages];
  pdc_div_t d_q [DivStages];
  pdc_div_t d_d [DivStages];
  logic     en  [DivStages];

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[DivStages-1] = !v_q[DivStages-1] || !stall_i;
    for (int k = DivStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[DivStages-1];
  assign data_o  = d_q[DivStages-1];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic     vin;
    pdc_div_t din;
    assign vin = (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
    assign din = (k == 0) ? data_i  : d_q[(k == 0) ? 0 : k-1];

    // two quotient bits per stage
    always_comb begin
      d_d[k] = din;
      for (int s = 0; s < StepsPerStage; s++) begin
        for (int c = 0; c < NumChan; c++) begin
          d_d[k].ch[c] = div_step(d_d[k].ch[c], din.alpha);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && vin) begin
        d_q[k] <= d_d[k];
      end
    end
  end

endmodule

// ===== rtl/core/porter_duff_compositor.sv =====
// Porter-Duff compositor, one 8-bit BGRA pixel per transaction.
// Pipeline: 3 front stages and 4 divider stages resolving 2 quotient bits each.
// Throughput: one pixel per clock while the output is not stalled; bubbles collapse while the output stalls.
// Reset (rst_ni low, asynchronous) empties the pipeline; no other state.
module porter_duff_compositor
  import pdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] opcode_i,
  input  logic [7:0] src_blue_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_alpha_i,
  input  logic [7:0] dst_blue_i,
  input  logic [7:0] dst_green_i,
  input  logic [7:0] dst_red_i,
  input  logic [7:0] dst_alpha_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_alpha_o
);

  typedef struct packed {
    pdc_op_e                 op;
    logic [7:0]              sa;
    logic [7:0]              da;
    logic [NumChan-1:0][7:0] s;
    logic [NumChan-1:0][7:0] d;
    logic [NumChan-1:0][7:0] ps;
    logic [NumChan-1:0][7:0] pd;
    logic [7:0]              m_sada;
    logic [7:0]              m_alt;
  } s1_t;

  typedef struct packed {
    pdc_mode_e               mode;
    logic [7:0]              alpha;
    logic [NumChan-1:0][8:0] c;
    logic [NumChan-1:0][7:0] pv;
  } s2_t;

  s1_t      s1_d, s1_q;
  s2_t      s2_d, s2_q;
  pdc_div_t s3_d, s3_q;
  logic     v1_q, v2_q, v3_q;
  logic     en1, en2, en3;
  logic     div_stall;
  pdc_div_t div_out;

  // elastic enables
  assign en3        = !v3_q || !div_stall;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: premultiply and alpha products
  always_comb begin
    s1_d.op = pdc_op_e'(opcode_i);
    s1_d.sa = src_alpha_i;
    s1_d.da = dst_alpha_i;
    s1_d.s  = {src_red_i, src_green_i, src_blue_i};
    s1_d.d  = {dst_red_i, dst_green_i, dst_blue_i};
    for (int c = 0; c < NumChan; c++) begin
      s1_d.ps[c] = mul255(s1_d.s[c], src_alpha_i);
      s1_d.pd[c] = mul255(s1_d.d[c], dst_alpha_i);
    end
    s1_d.m_sada = mul255(src_alpha_i, dst_alpha_i);
    if (pdc_op_e'(opcode_i) == OP_OUT) begin
      s1_d.m_alt = mul255(src_alpha_i, FullScale - dst_alpha_i);
    end else begin
      s1_d.m_alt = mul255(dst_alpha_i, FullScale - src_alpha_i);
    end
  end

  // stage 2: operator weights, color mix and result alpha
  always_comb begin
    logic [7:0] fa, fb, isa, ida;
    logic [8:0] sum, both, xr;
    isa = FullScale - s1_q.sa;
    ida = FullScale - s1_q.da;
    sum  = 9'(s1_q.sa) + 9'(s1_q.da);
    both = {s1_q.m_sada, 1'b0};
    xr   = (sum > both) ? (sum - both) : 9'd0;
    fa = 8'd0;
    fb = 8'd0;
    s2_d.mode  = MODE_ZERO;
    s2_d.alpha = 8'd0;
    case (s1_q.op)
      OP_SRC:      begin s2_d.mode = MODE_SRC; s2_d.alpha = s1_q.sa;     end
      OP_IN:       begin s2_d.mode = MODE_SRC; s2_d.alpha = s1_q.m_sada; end
      OP_OUT:      begin s2_d.mode = MODE_SRC; s2_d.alpha = s1_q.m_alt;  end
      OP_DST:      begin s2_d.mode = MODE_DST; s2_d.alpha = s1_q.da;     end
      OP_DST_IN:   begin s2_d.mode = MODE_DST; s2_d.alpha = s1_q.m_sada; end
      OP_DST_OUT:  begin s2_d.mode = MODE_DST; s2_d.alpha = s1_q.m_alt;  end
      OP_OVER, OP_DST_OVER: begin
        s2_d.mode  = MODE_MIX;
        s2_d.alpha = 8'(sum - 9'(s1_q.m_sada));
        fa = (s1_q.op == OP_OVER) ? FullScale : ida;
        fb = (s1_q.op == OP_OVER) ? isa : FullScale;
      end
      OP_ATOP:     begin s2_d.mode = MODE_MIX; s2_d.alpha = s1_q.da; fa = s1_q.da; fb = isa; end
      OP_DST_ATOP: begin s2_d.mode = MODE_MIX; s2_d.alpha = s1_q.sa; fa = ida; fb = s1_q.sa; end
      OP_XOR: begin
        s2_d.mode  = MODE_MIX;
        s2_d.alpha = xr[8] ? FullScale : xr[7:0];
        fa = ida;
        fb = isa;
      end
      default: begin
        s2_d.mode  = MODE_ZERO;
        s2_d.alpha = 8'd0;
      end
    endcase
    for (int c = 0; c < NumChan; c++) begin
      s2_d.c[c]  = 9'(mul255(s1_q.ps[c], fa)) + 9'(mul255(s1_q.pd[c], fb));
      s2_d.pv[c] = (s2_d.mode == MODE_DST) ? s1_q.d[c] : s1_q.s[c];
    end
  end

  // stage 3: dividend c*255 + a/2, saturation and fixed results
  always_comb begin
    logic [16:0] n;
    s3_d.alpha = s2_q.alpha;
    for (int c = 0; c < NumChan; c++) begin
      n = 17'({s2_q.c[c], 8'd0}) - 17'(s2_q.c[c]) + 17'(s2_q.alpha >> 1);
      s3_d.ch[c].rem = n[15:8];
      s3_d.ch[c].num = n[7:0];
      s3_d.ch[c].fix = 1'b1;
      s3_d.ch[c].quo = 8'd0;
      if (s2_q.alpha != 8'd0) begin
        case (s2_q.mode)
          MODE_SRC, MODE_DST: s3_d.ch[c].quo = s2_q.pv[c];
          MODE_MIX: begin
            if (n[16:8] >= {1'b0, s2_q.alpha}) begin
              s3_d.ch[c].quo = FullScale;
            end else begin
              s3_d.ch[c].fix = 1'b0;
            end
          end
          default: s3_d.ch[c].quo = 8'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= s1_d;
    if (en2 && v1_q)       s2_q <= s2_d;
    if (en3 && v2_q)       s3_q <= s3_d;
  end

  pdc_unpremul u_unpremul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .stall_o (div_stall),
    .data_i  (s3_q),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (div_out)
  );

  assign out_blue_o  = div_out.ch[0].quo;
  assign out_green_o = div_out.ch[1].quo;
  assign out_red_o   = div_out.ch[2].quo;
  assign out_alpha_o = div_out.alpha;

  // input stall only when the whole front end is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a free front stage");

  // a held stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> (v1_q && $stable(s1_q)))
    else $error("stage 1 lost a stalled transaction");

  // zero alpha gives black
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_alpha_o == 8'd0) |->
      (out_blue_o == 8'd0 && out_green_o == 8'd0 && out_red_o == 8'd0))
    else $error("nonzero color with zero alpha");

endmodule

// ===== tb/testbench.sv =====
module testbench
  import pdc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pixel_t;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainCycles = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [3:0] opcode_i;
  logic [7:0] src_blue_i, src_green_i, src_red_i, src_alpha_i;
  logic [7:0] dst_blue_i, dst_green_i, dst_red_i, dst_alpha_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_blue_o, out_green_o, out_red_o, out_alpha_o;

  pixel_t      expected_pixels[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned stall_mode;

  porter_duff_compositor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .src_blue_i  (src_blue_i),
    .src_green_i (src_green_i),
    .src_red_i   (src_red_i),
    .src_alpha_i (src_alpha_i),
    .dst_blue_i  (dst_blue_i),
    .dst_green_i (dst_green_i),
    .dst_red_i   (dst_red_i),
    .dst_alpha_i (dst_alpha_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o),
    .out_alpha_o (out_alpha_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Rounded x*y/255
  function automatic int unsigned scale(input int unsigned x, input int unsigned y);
    return (x * y + 127) / 255;
  endfunction

  // Divide premultiplied color back by alpha, saturated
  function automatic int unsigned unscale(input int unsigned c, input int unsigned a);
    int unsigned v;
    if (a == 0) return 0;
    v = (c * 255 + a / 2) / a;
    return (v > 255) ? 255 : v;
  endfunction

  // Composite one source and destination pixel
  function automatic pixel_t composite(input logic [3:0] op, input pixel_t s, input pixel_t d);
    int unsigned sc[3], dc[3], ps[3], pd[3], oc[3];
    int unsigned sa, da, oa, both;
    pixel_t r;
    sa = 32'(s.alpha);
    da = 32'(d.alpha);
    sc = '{32'(s.blue), 32'(s.green), 32'(s.red)};
    dc = '{32'(d.blue), 32'(d.green), 32'(d.red)};
    oa = 0;
    for (int i = 0; i < 3; i++) begin
      ps[i] = scale(sc[i], sa);
      pd[i] = scale(dc[i], da);
      oc[i] = 0;
    end
    case (op)
      OP_SRC, OP_IN, OP_OUT: begin
        oc = sc;
        oa = (op == OP_SRC) ? sa : (op == OP_IN) ? scale(sa, da) : scale(sa, 255 - da);
      end
      OP_DST, OP_DST_IN, OP_DST_OUT: begin
        oc = dc;
        oa = (op == OP_DST) ? da : (op == OP_DST_IN) ? scale(da, sa) : scale(da, 255 - sa);
      end
      OP_OVER: begin
        oa = sa + da - scale(sa, da);
        for (int i = 0; i < 3; i++) oc[i] = unscale(ps[i] + scale(pd[i], 255 - sa), oa);
      end
      OP_DST_OVER: begin
        oa = da + sa - scale(da, sa);
        for (int i = 0; i < 3; i++) oc[i] = unscale(pd[i] + scale(ps[i], 255 - da), oa);
      end
      OP_ATOP: begin
        oa = da;
        for (int i = 0; i < 3; i++)
          oc[i] = unscale(scale(ps[i], da) + scale(pd[i], 255 - sa), oa);
      end
      OP_DST_ATOP: begin
        oa = sa;
        for (int i = 0; i < 3; i++)
          oc[i] = unscale(scale(pd[i], sa) + scale(ps[i], 255 - da), oa);
      end
      OP_XOR: begin
        both = 2 * scale(sa, da);
        oa = (sa + da > both) ? sa + da - both : 0;
        if (oa > 255) oa = 255;
        for (int i = 0; i < 3; i++)
          oc[i] = unscale(scale(ps[i], 255 - da) + scale(pd[i], 255 - sa), oa);
      end
      default: oa = 0;
    endcase
    if (oa > 255) oa = 255;
    // zero coverage forces black
    if (oa == 0) oc = '{0, 0, 0};
    r.blue  = oc[0][7:0];
    r.green = oc[1][7:0];
    r.red   = oc[2][7:0];
    r.alpha = oa[7:0];
    return r;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one transaction; held until accepted
  task automatic send_pixel(input logic [3:0] op, input pixel_t s, input pixel_t d);
    opcode_i    <= op;
    src_blue_i  <= s.blue;
    src_green_i <= s.green;
    src_red_i   <= s.red;
    src_alpha_i <= s.alpha;
    dst_blue_i  <= d.blue;
    dst_green_i <= d.green;
    dst_red_i   <= d.red;
    dst_alpha_i <= d.alpha;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_pixels.push_back(composite(op, s, d));
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p.alpha = 8'd0;
      1: p.alpha = 8'd255;
      2: p.alpha = 8'($urandom_range(1, 3));
      default: ;
    endcase
    return p;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report("unexpected result alpha", 32'(out_alpha_o), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_blue_o !== want.blue) report("blue", 32'(out_blue_o), 32'(want.blue));
        if (out_green_o !== want.green) report("green", 32'(out_green_o), 32'(want.green));
        if (out_red_o !== want.red) report("red", 32'(out_red_o), 32'(want.red));
        if (out_alpha_o !== want.alpha) report("alpha", 32'(out_alpha_o), 32'(want.alpha));
      end
    end
  end

  // Receiver stall pattern, changed at the falling edge
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Corner values and every operator
  task automatic test_directed();
    pixel_t s, d;
    for (int op = 0; op < 16; op++) begin
      s = {8'd255, 8'd0, 8'd128, 8'd200};
      d = {8'd10, 8'd255, 8'd77, 8'd100};
      send_pixel(op[3:0], s, d);
    end
    send_pixel(OP_OVER, 32'hffffffff, 32'hffffffff);
    send_pixel(OP_OVER, 32'h00000000, 32'h00000000);
    send_pixel(OP_XOR, 32'hffffffff, 32'hffffffff);
    send_pixel(OP_XOR, {24'hff00ff, 8'd1}, {24'h00ff00, 8'd1});
    send_pixel(OP_ATOP, {24'hffffff, 8'd255}, {24'hffffff, 8'd0});
    send_pixel(OP_DST_ATOP, {24'hffffff, 8'd0}, {24'hffffff, 8'd255});
    send_pixel(OP_IN, {24'h123456, 8'd255}, {24'hffffff, 8'd0});
    send_pixel(OP_DST_OUT, {24'h123456, 8'd255}, {24'hffffff, 8'd255});
    idle_gap(1);
  endtask

  // Random pixels in bursts
  task automatic test_random(input int unsigned count);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_pixel($urandom_range(0, 19) == 0 ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11)),
                   rand_pixel(), rand_pixel());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    idle_gap(1);
  endtask

  // Hold off until the pipeline has fully drained, then send 100 random pixels
  task automatic test_drain_pause();
    while (expected_pixels.size() != 0) @(negedge clk_i);
    test_random(100);
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    stall_mode = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    opcode_i = '0;
    {src_blue_i, src_green_i, src_red_i, src_alpha_i} = '0;
    {dst_blue_i, dst_green_i, dst_red_i, dst_alpha_i} = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(650);
    test_drain_pause();
    test_random(650);
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
